// ----- hw/rtl/tsp_pkg.sv -----
// Package for the tone sequence player: widths, reset values and codes.
// Used by tsp_div and tone_sequence_player; depends on nothing.
`default_nettype none

package tsp_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned SONG_W   = 7;
  localparam int unsigned CMP_W    = 16;
  localparam int unsigned COUNT_W  = 20;
  localparam int unsigned DIV_W    = 9;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
  localparam logic [CMP_W-1:0]   RESET_COMPARE    = 16'd1000;
  localparam logic [CMP_W-1:0]   RESET_SILENT     = 16'd1000;
  localparam logic [SONG_W-1:0]  RESET_SONG_LEN   = 7'd1;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SONG_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENT_COMPARE = 2'd1;

endpackage

`default_nettype wire

// ----- hw/rtl/tsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`default_nettype none

module tsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tsp_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tsp_pkg for the count and divisor widths.
`default_nettype none

module tsp_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tsp_pkg::COUNT_W-1:0]  dividend_i,
  input  wire logic [tsp_pkg::DIV_W-1:0]    divisor_i,
  output logic                              done_o,
  output logic      [tsp_pkg::COUNT_W-1:0]  quotient_o
);

  import tsp_pkg::*;

  localparam int unsigned CNT_W = $clog2(COUNT_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COUNT_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0]   rem_q, rem_d;
  logic [DIV_W-1:0]   div_q;
  logic [DIV_W:0]     trial;
  logic               ge;

  always_comb begin
    trial = {rem_q, quo_q[COUNT_W-1]};
    ge    = trial >= {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(COUNT_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[COUNT_W-2:0], ge};
      rem_d = ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tone_sequence_player.sv -----
// Top level of the tone sequence player: note table, sequencer and result register.
// Depends on tsp_pkg, tsp_ram and tsp_div.
//
// A write request stores one table entry. A tick request whose count is
// still running decrements it and offers its result in the next cycle. A tick that
// loads a note does a table read, then a load for a rest or a very short period; for
// a tone the count is worked out first by a bit-serial divider that delivers one of
// its 20 quotient bits per cycle. One request is in work at a time;
// a new one is taken once the result register is free or being read in the same cycle.
// The table needs no clearing after reset; configuration writes are taken at any time.
`default_nettype none

module tone_sequence_player #(
  parameter int unsigned TABLE_DEPTH = tsp_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            cmd_i,
  input  wire logic [tsp_pkg::INDEX_W-1:0]     entry_index_i,
  input  wire logic [tsp_pkg::PERIOD_W-1:0]    entry_period_i,
  input  wire logic [tsp_pkg::LENGTH_W-1:0]    entry_length_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 new_note_o,
  output logic      [tsp_pkg::CMP_W-1:0]       compare_value_o,
  output logic                                 pin_mode_o,
  output logic                                 indicator_o,
  output logic      [tsp_pkg::INDEX_W-1:0]     position_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tsp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tsp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import tsp_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned PW   = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int unsigned LW   = (AW + 1 > SONG_W) ? AW + 1 : SONG_W;
  localparam int unsigned RAMW = PERIOD_W + LENGTH_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      cursor_q, cursor_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [CMP_W-1:0]   cmp_q, cmp_d;
  logic               mode_q, mode_d;
  logic               ind_q, ind_d;
  logic [SONG_W-1:0]  song_len_q, song_len_d;
  logic [CMP_W-1:0]   silent_q, silent_d;
  logic               out_valid_q, out_valid_d;
  logic               new_note_q, new_note_d;

  logic                tick_acc, wr_acc;
  logic                ram_re;
  logic [RAMW-1:0]     ram_rdata;
  logic [PW-1:0]       idx_ext, pos_ext;
  logic                idx_ok;
  logic [PERIOD_W-1:0] rd_period;
  logic [LENGTH_W-1:0] rd_length;
  logic [LW-1:0]       eff_len, next_pos;
  logic [AW-1:0]       cursor_next;
  logic                div_start, div_done;
  logic [COUNT_W-1:0]  quotient;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign tick_acc    = in_valid_i && in_ready_o && (cmd_i == CMD_TICK);
  assign wr_acc      = in_valid_i && in_ready_o && (cmd_i == CMD_WRITE);
  assign cfg_ready_o = 1'b1;

  assign idx_ext = PW'(entry_index_i);
  assign idx_ok  = (PW + 1)'(idx_ext) < (PW + 1)'(TABLE_DEPTH);

  tsp_ram #(
    .WIDTH (RAMW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_acc && idx_ok),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i ({entry_period_i, entry_length_i}),
    .re_i    (ram_re),
    .raddr_i (cursor_q),
    .rdata_o (ram_rdata)
  );

  assign rd_period = ram_rdata[RAMW-1:LENGTH_W];
  assign rd_length = ram_rdata[LENGTH_W-1:0];

  tsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({rd_length, 4'b0000}),
    .divisor_i  (rd_period[PERIOD_W-1:PERIOD_W-DIV_W]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    if (song_len_q == '0) begin
      eff_len = LW'(1);
    end else if (LW'(song_len_q) > LW'(TABLE_DEPTH)) begin
      eff_len = LW'(TABLE_DEPTH);
    end else begin
      eff_len = LW'(song_len_q);
    end
    next_pos    = LW'(cursor_q) + 1'b1;
    cursor_next = (next_pos >= eff_len) ? '0 : next_pos[AW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    rem_d       = rem_q;
    cmp_d       = cmp_q;
    mode_d      = mode_q;
    ind_d       = ind_q;
    song_len_d  = song_len_q;
    silent_d    = silent_q;
    out_valid_d = out_valid_q && !out_ready_i;
    new_note_d  = new_note_q;
    ram_re      = 1'b0;
    div_start   = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SONG_LENGTH:    song_len_d = cfg_data_i[SONG_W-1:0];
        CFG_SILENT_COMPARE: silent_d   = cfg_data_i[CMP_W-1:0];
        default:            ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (tick_acc) begin
          if (rem_q == '0) begin
            ram_re  = 1'b1;
            state_d = S_READ;
          end else begin
            rem_d       = rem_q - 1'b1;
            out_valid_d = 1'b1;
            new_note_d  = 1'b0;
          end
        end
      end
      S_READ: begin
        ind_d    = ~ind_q;
        cursor_d = cursor_next;
        if (rd_period[PERIOD_W-1:1] == '0) begin
          // rest: silent compare, pin held low, plain duration
          mode_d      = 1'b1;
          cmp_d       = silent_q;
          rem_d       = COUNT_W'(rd_length);
          out_valid_d = 1'b1;
          new_note_d  = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mode_d = 1'b0;
          cmp_d  = {1'b0, rd_period[PERIOD_W-1:1]};
          if (rd_period[PERIOD_W-1:PERIOD_W-DIV_W] == '0) begin
            rem_d       = COUNT_MAX;
            out_valid_d = 1'b1;
            new_note_d  = 1'b1;
            state_d     = S_IDLE;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          rem_d       = quotient;
          out_valid_d = 1'b1;
          new_note_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cursor_q    <= '0;
      rem_q       <= '0;
      cmp_q       <= RESET_COMPARE;
      mode_q      <= 1'b0;
      ind_q       <= 1'b0;
      song_len_q  <= RESET_SONG_LEN;
      silent_q    <= RESET_SILENT;
      out_valid_q <= 1'b0;
      new_note_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      rem_q       <= rem_d;
      cmp_q       <= cmp_d;
      mode_q      <= mode_d;
      ind_q       <= ind_d;
      song_len_q  <= song_len_d;
      silent_q    <= silent_d;
      out_valid_q <= out_valid_d;
      new_note_q  <= new_note_d;
    end
  end

  assign pos_ext         = PW'(cursor_q);
  assign out_valid_o     = out_valid_q;
  assign new_note_o      = new_note_q;
  assign compare_value_o = cmp_q;
  assign pin_mode_o      = mode_q;
  assign indicator_o     = ind_q;
  assign position_o      = pos_ext[INDEX_W-1:0];

  a_tick_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc && (rem_q != '0) |=> (rem_q == $past(rem_q) - 1'b1) && out_valid_q)
    else $error("running count not decremented by one");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  a_start_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (state_q == S_READ) && !out_valid_q)
    else $error("divider started with a result pending");

  a_tone_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> (cmp_q != '0))
    else $error("toggle mode with zero compare value");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (LW'(cursor_q) < eff_len) || (cursor_q == '0))
    else $error("cursor beyond song length after a load");

endmodule

`default_nettype wire

// ----- tb/sv/tone_sequence_player_tb.sv -----
// Self-checking testbench for tone_sequence_player: table writes, timer ticks, note loads.
// Holds its own note sequencer to predict each tick result; needs tsp_pkg and the RTL only.
`default_nettype none

module tone_sequence_player_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic               new_note;
    logic [CMP_W-1:0]   compare_value;
    logic               pin_mode;
    logic               indicator;
    logic [INDEX_W-1:0] position;
  } tone_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid  = 1'b0;
  logic                  in_cmd    = CMD_TICK;
  logic [INDEX_W-1:0]    in_index  = '0;
  logic [PERIOD_W-1:0]   in_period = '0;
  logic [LENGTH_W-1:0]   in_length = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SONG_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                  in_ready;
  logic                  out_valid;
  logic                  res_new_note;
  logic [CMP_W-1:0]      res_compare;
  logic                  res_pin_mode;
  logic                  res_indicator;
  logic [INDEX_W-1:0]    res_position;
  logic                  cfg_ready;

  // sequencer prediction
  logic [PERIOD_W-1:0] period_mem [DEPTH];
  logic [LENGTH_W-1:0] length_mem [DEPTH];
  logic [INDEX_W-1:0]  pl_cursor   = '0;
  logic [COUNT_W-1:0]  pl_count    = '0;
  logic [CMP_W-1:0]    pl_compare  = RESET_COMPARE;
  logic                pl_mode     = 1'b0;
  logic                pl_ind      = 1'b0;
  logic [SONG_W-1:0]   pl_song_len = RESET_SONG_LEN;
  logic [CMP_W-1:0]    pl_silent   = RESET_SILENT;
  int unsigned         load_count  = 0;
  tone_result_t        expected_notes [$];

  int unsigned cycle_count   = 0;
  int unsigned err_count     = 0;
  int unsigned burst_left    = 0;
  bit          eager         = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned rx_cycles     = 0;

  tone_sequence_player dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (in_cmd),
    .entry_index_i  (in_index),
    .entry_period_i (in_period),
    .entry_length_i (in_length),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .new_note_o     (res_new_note),
    .compare_value_o(res_compare),
    .pin_mode_o     (res_pin_mode),
    .indicator_o    (res_indicator),
    .position_o     (res_position),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch, cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
               want);
  endtask

  function automatic int unsigned eff_song_len();
    if (pl_song_len == 0) return 1;
    if (pl_song_len > DEPTH) return DEPTH;
    return pl_song_len;
  endfunction

  function automatic void play_tick();
    logic [CMP_W-1:0]    half;
    logic [LENGTH_W-1:0] dur;
    int unsigned         steps;
    int unsigned         next_pos;
    tone_result_t        r;
    r.new_note = (pl_count == 0);
    if (r.new_note) begin
      pl_ind = ~pl_ind;
      half = period_mem[pl_cursor] >> 1;
      dur = length_mem[pl_cursor];
      if (half == 0) begin
        pl_mode = 1'b1;
        pl_compare = pl_silent;
        pl_count = COUNT_W'(dur);
      end else begin
        pl_mode = 1'b0;
        pl_compare = half;
        steps = half >> 6;
        if (steps == 0) pl_count = COUNT_MAX;
        else pl_count = COUNT_W'((int'(dur) * 16) / steps);
      end
      next_pos = int'(pl_cursor) + 1;
      if (next_pos >= eff_song_len()) next_pos = 0;
      pl_cursor = INDEX_W'(next_pos);
      load_count++;
    end else begin
      pl_count = pl_count - 1'b1;
    end
    r.compare_value = pl_compare;
    r.pin_mode = pl_mode;
    r.indicator = pl_ind;
    r.position = pl_cursor;
    expected_notes.push_back(r);
  endfunction

  // tones with a count of at most four, rests of a few ticks
  function automatic void pick_safe_entry(output logic [PERIOD_W-1:0] per,
                                          output logic [LENGTH_W-1:0] len);
    int unsigned steps;
    if ($urandom_range(0, 3) == 0) begin
      per = PERIOD_W'($urandom_range(0, 1));
      len = LENGTH_W'($urandom_range(0, 6));
    end else begin
      per = PERIOD_W'($urandom_range(16'h2000, 16'hFFFF));
      steps = per >> 7;
      len = LENGTH_W'($urandom_range(0, steps / 4));
    end
  endfunction

  task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                           input logic [PERIOD_W-1:0] per, input logic [LENGTH_W-1:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = eager ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 30)
                                                   : $urandom_range(0, 4));
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_index  <= idx;
    in_period <= per;
    in_length <= len;
    do @(posedge clk_i); while (!in_ready);
    if (cmd == CMD_TICK) begin
      play_tick();
    end else begin
      period_mem[idx] = per;
      length_mem[idx] = len;
    end
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, INDEX_W'($urandom), PERIOD_W'($urandom), LENGTH_W'($urandom));
  endtask

  task automatic tick_until_loads(input int unsigned n);
    int unsigned target;
    target = load_count + n;
    while (load_count < target) send_tick();
  endtask

  // no request in flight and every result drained
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_SONG_LENGTH:    pl_song_len = data[SONG_W-1:0];
      CFG_SILENT_COMPARE: pl_silent = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_side
    tone_result_t want;
    rx_cycles++;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_notes.size() == 0) begin
        report_mismatch("result with nothing pending", res_compare, 0);
      end else begin
        want = expected_notes.pop_front();
        if (res_new_note !== want.new_note)
          report_mismatch("new_note", res_new_note, want.new_note);
        if (res_compare !== want.compare_value)
          report_mismatch("compare_value", res_compare, want.compare_value);
        if (res_pin_mode !== want.pin_mode)
          report_mismatch("pin_mode", res_pin_mode, want.pin_mode);
        if (res_indicator !== want.indicator)
          report_mismatch("indicator", res_indicator, want.indicator);
        if (res_position !== want.position)
          report_mismatch("position", res_position, want.position);
      end
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycles >> 9) % 3)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 2) != 0);
        default: out_ready <= ((rx_cycles % 7) < 4);
      endcase
    end
  end

  task automatic test_fill_table();
    logic [PERIOD_W-1:0] per;
    logic [LENGTH_W-1:0] len;
    for (int i = 0; i < DEPTH; i++) begin
      pick_safe_entry(per, len);
      send_item(CMD_WRITE, INDEX_W'(i), per, len);
    end
  endtask

  task automatic test_note_kinds();
    settle();
    write_config(CFG_SONG_LENGTH, 16'd8);
    send_item(CMD_WRITE, 6'd0, 16'd0, 16'd2);
    send_item(CMD_WRITE, 6'd1, 16'd1, 16'd0);
    send_item(CMD_WRITE, 6'd2, 16'hFFFF, 16'd1);
    send_item(CMD_WRITE, 6'd3, 16'd128, 16'd0);
    send_item(CMD_WRITE, 6'd4, 16'd8192, 16'd3);
    send_item(CMD_WRITE, 6'd5, 16'd16384, 16'd100);
    send_item(CMD_WRITE, 6'd6, 16'd0, 16'd0);
    send_item(CMD_WRITE, 6'd7, 16'hFFFE, 16'd0);
    tick_until_loads(8);
  endtask

  task automatic test_cursor_past_end();
    settle();
    write_config(CFG_SONG_LENGTH, 16'd8);
    while (pl_cursor != 6) send_tick();
    settle();
    write_config(CFG_SONG_LENGTH, 16'd3);
    tick_until_loads(2);
  endtask

  task automatic test_song_length_limits();
    settle();
    write_config(CFG_SONG_LENGTH, 16'd0);
    tick_until_loads(3);
    settle();
    write_config(CFG_SONG_LENGTH, 16'hFFFF);
    while (pl_cursor != DEPTH - 1) send_tick();
    tick_until_loads(2);
    settle();
    write_config(CFG_SONG_LENGTH, 16'd65);
    tick_until_loads(3);
  endtask

  task automatic test_silent_compare();
    settle();
    write_config(CFG_SONG_LENGTH, 16'd2);
    send_item(CMD_WRITE, 6'd0, 16'd0, 16'd1);
    send_item(CMD_WRITE, 6'd1, 16'd1, 16'd0);
    settle();
    write_config(CFG_SILENT_COMPARE, 16'd1);
    tick_until_loads(2);
    settle();
    write_config(CFG_SILENT_COMPARE, 16'hFFFF);
    tick_until_loads(2);
    settle();
    write_config(CFG_SILENT_COMPARE, 16'd0);
    tick_until_loads(2);
    settle();
    write_config(CFG_SPARE_2, CFG_DATA_W'($urandom));
    write_config(CFG_SPARE_3, CFG_DATA_W'($urandom));
    write_config(CFG_SILENT_COMPARE, CFG_DATA_W'($urandom));
    tick_until_loads(3);
  endtask

  // long note: wide dividend against the largest divisor
  task automatic test_long_note();
    logic [PERIOD_W-1:0] per;
    logic [LENGTH_W-1:0] len;
    logic [INDEX_W-1:0]  slot;
    settle();
    write_config(CFG_SONG_LENGTH, 16'd64);
    slot = pl_cursor;
    send_item(CMD_WRITE, slot, 16'hFFFF, 16'h1FFF);
    tick_until_loads(1);
    pick_safe_entry(per, len);
    send_item(CMD_WRITE, slot, per, len);
    tick_until_loads(1);
  endtask

  task automatic test_random_traffic();
    logic [PERIOD_W-1:0] per;
    logic [LENGTH_W-1:0] len;
    int unsigned         song;
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      if (phase == 0) song = 1;
      else if (phase == 1) song = 64;
      else if ($urandom_range(0, 4) == 0) song = $urandom_range(0, 127);
      else song = $urandom_range(2, 12);
      write_config(CFG_SONG_LENGTH, {9'($urandom), 7'(song)});
      write_config(CFG_SILENT_COMPARE, CFG_DATA_W'($urandom));
      eager = (phase % 4 == 3);
      for (int n = 0; n < 50; n++) begin
        if (phase == 2 && n == 20) hold_requests++;
        if (phase == 6 && n == 25) settle();
        if ($urandom_range(0, 3) == 0) begin
          pick_safe_entry(per, len);
          send_item(CMD_WRITE, INDEX_W'($urandom), per, len);
        end else begin
          send_tick();
        end
      end
    end
    eager = 1'b0;
  endtask

  // saturated count: nothing can be loaded after this, so it runs last
  task automatic test_zero_divisor();
    send_item(CMD_WRITE, pl_cursor, 16'd127, 16'd9);
    tick_until_loads(1);
    repeat (8) send_tick();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      period_mem[i] = '0;
      length_mem[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_table();
    test_note_kinds();
    test_cursor_past_end();
    test_song_length_limits();
    test_silent_compare();
    test_long_note();
    test_random_traffic();
    test_zero_divisor();
    settle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
